/* src/deque_with_search_macros.svh */
// ----------------------------------------------------------------------------
// Deque with search: assertion macros
// Short forms for the concurrent checks of the deque block, clocked on clk_i
// and switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication
`define DWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/dws_pkg.sv */
// ----------------------------------------------------------------------------
// Deque with search: package
// Action and status codes, state encoding and default sizes.
// ----------------------------------------------------------------------------
package dws_pkg;

  localparam int unsigned DepthDefault = 32;

  localparam int unsigned ActionW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 6;
  localparam int unsigned OccW    = 6;

  typedef enum logic [ActionW-1:0] {
    ActPushFront = 3'd0,
    ActPushBack  = 3'd1,
    ActPopFront  = 3'd2,
    ActPopBack   = 3'd3,
    ActList      = 3'd4,
    ActSearch    = 3'd5,
    ActCount     = 3'd6
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StsPushed   = 3'd0,
    StsPopped   = 3'd1,
    StsEmpty    = 3'd2,
    StsListed   = 3'd3,
    StsFound    = 3'd4,
    StsNotFound = 3'd5,
    StsCount    = 3'd6,
    StsFull     = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StPop   = 4'b0010,
    StScan  = 4'b0100,
    StFlush = 4'b1000
  } state_e;

endpackage

/* src/deque_with_search.sv */
// ----------------------------------------------------------------------------
// Deque with search
// Bounded double-ended queue of signed 32-bit values in a ring memory, with
// push, pop, list, search and count actions.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Each result is
// shown for exactly one cycle with result_valid_o high and must be captured
// then: there is no way to hold results off. Push and count answer in the
// cycle after the item, with busy_o staying low, so pushes and counts may
// follow each other every cycle. A pop reads the ring memory through the
// registered read port, answers from the StPop state and is busy in StPop.
// List walks the stored entries one memory read per cycle and gives one
// result per entry, the last one with last_o high. Search walks the same way
// and holds each match back until the next match or the end of the walk, so
// that the last match can carry last_o; it gives one result per match or a
// single not-found result. Pops, lists and searches on an empty ring and
// pushes into a full ring answer with one empty or full result. The
// single-port-read ring memory sets the walking speed. Unused action codes
// are dropped without a result. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`include "deque_with_search_macros.svh"

module deque_with_search #(
  parameter int unsigned DEPTH = dws_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [dws_pkg::ActionW-1:0]       action_i,
  input  logic signed [dws_pkg::ValueW-1:0] value_i,
  output logic                              result_valid_o,
  output logic [dws_pkg::StatusW-1:0]       status_o,
  output logic signed [dws_pkg::ValueW-1:0] item_value_o,
  output logic [dws_pkg::PosW-1:0]          position_o,
  output logic [dws_pkg::OccW-1:0]          occupancy_o,
  output logic                              last_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [PW:0]   DepthW = (PW + 1)'(DEPTH);

  // Wrap a ring sum that stays below twice the depth
  function automatic logic [PW-1:0] wrap(input logic [PW:0] s);
    logic [PW:0] t;
    t = (s >= DepthW) ? (s - DepthW) : s;
    return t[PW-1:0];
  endfunction

  // Ring memory: one write and one registered read per cycle
  logic [dws_pkg::ValueW-1:0] mem [DEPTH];
  logic                       mem_we;
  logic [PW-1:0]              mem_waddr;
  logic [PW-1:0]              mem_raddr;
  logic [dws_pkg::ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= value_i;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Control state
  dws_pkg::state_e state_q, state_d;
  logic [PW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] off_q, off_d;
  logic [PW-1:0] scan_addr_q, scan_addr_d;
  logic          is_search_q, is_search_d;
  logic          pend_valid_q, pend_valid_d;
  logic [CW-1:0] pend_pos_q, pend_pos_d;

  // Search key, payload only
  logic [dws_pkg::ValueW-1:0] key_q, key_d;

  // Result register
  logic                       res_valid_q, res_valid_d;
  dws_pkg::status_e           status_q, status_d;
  logic [dws_pkg::ValueW-1:0] res_value_q, res_value_d;
  logic [CW-1:0]              res_pos_q, res_pos_d;
  logic [dws_pkg::OccW-1:0]   occ_q;
  logic                       last_q, last_d;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic [PW:0]   tail_sum;
  logic [CW-1:0] off_inc;
  logic          scan_final;
  logic          scan_match;

  assign accept     = start_i && (state_q == dws_pkg::StIdle);
  assign is_full    = (count_q == DepthC);
  assign is_empty   = (count_q == '0);
  assign tail_sum   = {1'b0, front_q} + (PW + 1)'(count_q);
  assign off_inc    = off_q + CW'(1);
  assign scan_final = (off_inc == count_q);
  assign scan_match = (rdata_q == key_q);

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    off_d        = off_q;
    scan_addr_d  = scan_addr_q;
    is_search_d  = is_search_q;
    pend_valid_d = pend_valid_q;
    pend_pos_d   = pend_pos_q;
    key_d        = key_q;
    res_valid_d  = 1'b0;
    status_d     = dws_pkg::StsPushed;
    res_value_d  = '0;
    res_pos_d    = '0;
    last_d       = 1'b1;
    mem_we       = 1'b0;
    mem_waddr    = front_q;
    mem_raddr    = scan_addr_q;

    case (state_q)
      dws_pkg::StIdle: begin
        if (accept) begin
          case (dws_pkg::action_e'(action_i))
            dws_pkg::ActPushFront, dws_pkg::ActPushBack: begin
              res_valid_d = 1'b1;
              if (is_full) begin
                status_d = dws_pkg::StsFull;
              end else begin
                mem_we = 1'b1;
                if (action_i == dws_pkg::ActPushFront) begin
                  front_d   = (front_q == '0) ? PW'(DEPTH - 1) : (front_q - PW'(1));
                  mem_waddr = front_d;
                end else begin
                  mem_waddr = wrap(tail_sum);
                end
                count_d  = count_q + CW'(1);
                status_d = dws_pkg::StsPushed;
              end
            end
            dws_pkg::ActPopFront, dws_pkg::ActPopBack: begin
              if (is_empty) begin
                res_valid_d = 1'b1;
                status_d    = dws_pkg::StsEmpty;
              end else begin
                if (action_i == dws_pkg::ActPopFront) begin
                  mem_raddr = front_q;
                  front_d   = wrap({1'b0, front_q} + (PW + 1)'(1));
                end else begin
                  mem_raddr = wrap(tail_sum - (PW + 1)'(1));
                end
                count_d = count_q - CW'(1);
                state_d = dws_pkg::StPop;
              end
            end
            dws_pkg::ActList, dws_pkg::ActSearch: begin
              if (is_empty) begin
                res_valid_d = 1'b1;
                status_d    = dws_pkg::StsEmpty;
              end else begin
                // Issue the first read now; walk from the next slot on
                mem_raddr    = front_q;
                scan_addr_d  = wrap({1'b0, front_q} + (PW + 1)'(1));
                off_d        = '0;
                key_d        = value_i;
                is_search_d  = (action_i == dws_pkg::ActSearch);
                pend_valid_d = 1'b0;
                state_d      = dws_pkg::StScan;
              end
            end
            dws_pkg::ActCount: begin
              res_valid_d = 1'b1;
              status_d    = dws_pkg::StsCount;
            end
            default: begin
            end
          endcase
        end
      end

      dws_pkg::StPop: begin
        res_valid_d = 1'b1;
        status_d    = dws_pkg::StsPopped;
        res_value_d = rdata_q;
        state_d     = dws_pkg::StIdle;
      end

      dws_pkg::StScan: begin
        // Read data belongs to offset off_q; advance the walk
        mem_raddr   = scan_addr_q;
        scan_addr_d = wrap({1'b0, scan_addr_q} + (PW + 1)'(1));
        off_d       = off_inc;
        if (!is_search_q) begin
          res_valid_d = 1'b1;
          status_d    = dws_pkg::StsListed;
          res_value_d = rdata_q;
          res_pos_d   = off_inc;
          last_d      = scan_final;
          if (scan_final) begin
            state_d = dws_pkg::StIdle;
          end
        end else begin
          // Hold each match back until the next one shows it is not the last
          if (scan_match) begin
            if (pend_valid_q) begin
              res_valid_d = 1'b1;
              status_d    = dws_pkg::StsFound;
              res_value_d = key_q;
              res_pos_d   = pend_pos_q;
              last_d      = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_pos_d   = off_inc;
          end
          if (scan_final) begin
            state_d = dws_pkg::StFlush;
          end
        end
      end

      dws_pkg::StFlush: begin
        res_valid_d = 1'b1;
        if (pend_valid_q) begin
          status_d    = dws_pkg::StsFound;
          res_value_d = key_q;
          res_pos_d   = pend_pos_q;
        end else begin
          status_d = dws_pkg::StsNotFound;
        end
        pend_valid_d = 1'b0;
        state_d      = dws_pkg::StIdle;
      end

      default: begin
        state_d = dws_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dws_pkg::StIdle;
      front_q      <= '0;
      count_q      <= '0;
      off_q        <= '0;
      scan_addr_q  <= '0;
      is_search_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_pos_q   <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      count_q      <= count_d;
      off_q        <= off_d;
      scan_addr_q  <= scan_addr_d;
      is_search_q  <= is_search_d;
      pend_valid_q <= pend_valid_d;
      pend_pos_q   <= pend_pos_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    status_q    <= status_d;
    res_value_q <= res_value_d;
    res_pos_q   <= res_pos_d;
    occ_q       <= dws_pkg::OccW'(count_d);
    last_q      <= last_d;
  end

  assign busy_o         = (state_q != dws_pkg::StIdle);
  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign item_value_o   = res_value_q;
  assign position_o     = dws_pkg::PosW'(res_pos_q);
  assign occupancy_o    = occ_q;
  assign last_o         = last_q;

  // Checks
  `DWS_ASSERT_NXT(a_push_answers, accept && !is_full && (action_i == dws_pkg::ActPushFront || action_i == dws_pkg::ActPushBack), res_valid_q && status_q == dws_pkg::StsPushed && last_q, "push into a ring with room did not answer pushed")
  `DWS_ASSERT_NXT(a_busy_count_stable, busy_o, $stable(count_q), "occupancy changed while busy")
  `DWS_ASSERT_IMP(a_scan_in_range, state_q == dws_pkg::StScan, off_q < count_q && count_q <= DepthC, "walk offset beyond occupancy")
  `DWS_ASSERT_NXT(a_flush_last, state_q == dws_pkg::StFlush, res_valid_q && last_q && state_q == dws_pkg::StIdle, "search did not close with a final result")

endmodule
